FILE: rtl/core/dmbp_pkg.sv
// package for the delta modulation byte packer
// holds constants, the controller state type and the control/status structs
// no dependencies
`default_nettype none

package dmbp_pkg;

	localparam int PAD_BLOCK  = 16;
	localparam int MAX_BLOCKS = 255;
	localparam int COUNT_W    = 13;
	localparam int COUNT_MAX  = (1 << COUNT_W) - 1;
	localparam int PAD_W      = (PAD_BLOCK > 2) ? $clog2(PAD_BLOCK) : 1;
	localparam int TOTAL_W    = 15;
	localparam int BLOCK_LIMIT = (MAX_BLOCKS + 1) * PAD_BLOCK;

	localparam logic [7:0] PAD_BYTE = 8'hAA;
	localparam logic [7:0] ODD_FILL = 8'hAA;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_END    = 1'b1;

	typedef enum logic [0:0] {
		ST_RUN,
		ST_PAD
	} state_t;

	typedef struct packed {
		logic accept_sample;
		logic accept_end;
		logic pad_emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic end_no_pad;
		logic pad_last;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/dmbp_ctrl.sv
// controller state machine for the delta modulation byte packer
// sequences sample and end transactions and the padding run; uses dmbp_pkg
`default_nettype none

module dmbp_ctrl
	import dmbp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_command,
	output logic            in_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q, state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		accept   = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_RUN: begin
				in_ready = status.slot_free;
				accept   = in_valid && status.slot_free;
				cmd.accept_sample = accept && (in_command == CMD_SAMPLE);
				cmd.accept_end    = accept && (in_command == CMD_END);
				if (cmd.accept_end && !status.end_no_pad) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				cmd.pad_emit = status.slot_free;
				if (status.slot_free && status.pad_last) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/dmbp_datapath.sv
// datapath for the delta modulation byte packer
// tracking level, bit packing, byte and pad counters, output register; uses dmbp_pkg
`default_nettype none

module dmbp_datapath
	import dmbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctrl_cmd_t   cmd,
	input  wire logic [15:0] sample,
	output dp_status_t       status,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_data,
	output logic             out_last,
	output logic             out_too_long
);

	logic signed [7:0]  level_q;
	logic [7:0]         bit_buffer_q;
	logic [2:0]         bit_count_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic [PAD_W-1:0]   mod_q;
	logic [PAD_W-1:0]   pad_left_q;
	logic               tl_q;
	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic               out_last_q;
	logic               out_tl_q;

	logic signed [16:0] lvl_scaled;
	logic signed [16:0] sample_ext;
	logic               bit_up;
	logic [7:0]         buffer_next;
	logic [7:0]         fin;
	logic [7:0]         fill_mask;
	logic               count_sat;
	logic [COUNT_W-1:0] bc_inc;
	logic [PAD_W-1:0]   mod_inc;
	logic [PAD_W-1:0]   pads;
	logic [TOTAL_W-1:0] total;
	logic               tl_end;
	logic               byte_done;

	assign lvl_scaled  = {level_q, 9'd0};
	assign sample_ext  = {sample[15], sample};
	assign bit_up      = lvl_scaled < sample_ext;
	assign buffer_next = bit_buffer_q | (8'(bit_up) << bit_count_q);
	assign byte_done   = cmd.accept_sample && (bit_count_q == 3'd7);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fill_mask[i] = (bit_count_q != 3'd0) && (3'(i) >= bit_count_q);
		end
	end

	assign fin = bit_buffer_q | (fill_mask & ODD_FILL);

	// saturating byte count, with its position inside the current pad block
	assign count_sat = byte_count_q == COUNT_W'(COUNT_MAX);
	assign bc_inc    = count_sat ? byte_count_q : byte_count_q + COUNT_W'(1);
	assign mod_inc   = count_sat ? mod_q :
		((mod_q == PAD_W'(PAD_BLOCK - 1)) ? '0 : mod_q + PAD_W'(1));
	assign pads      = (mod_inc <= PAD_W'(1)) ? PAD_W'(1) - mod_inc :
		PAD_W'(7'(PAD_BLOCK + 1) - 7'(mod_inc));
	assign total     = TOTAL_W'(bc_inc) + TOTAL_W'(pads);
	assign tl_end    = total > TOTAL_W'(BLOCK_LIMIT);

	assign status.slot_free  = !out_valid_q || out_ready;
	assign status.end_no_pad = pads == '0;
	assign status.pad_last   = pad_left_q == PAD_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			bit_buffer_q <= '0;
			bit_count_q  <= '0;
			byte_count_q <= '0;
			mod_q        <= '0;
			pad_left_q   <= '0;
			tl_q         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept_sample) begin
				if (bit_up) begin
					if (level_q != 8'sd127) begin
						level_q <= level_q + 8'sd1;
					end
				end else begin
					if (level_q != -8'sd128) begin
						level_q <= level_q - 8'sd1;
					end
				end
				bit_count_q <= bit_count_q + 3'd1;
				if (byte_done) begin
					bit_buffer_q <= '0;
					byte_count_q <= bc_inc;
					mod_q        <= mod_inc;
				end else begin
					bit_buffer_q <= buffer_next;
				end
			end
			if (cmd.accept_end) begin
				level_q      <= '0;
				bit_buffer_q <= '0;
				bit_count_q  <= '0;
				byte_count_q <= '0;
				mod_q        <= '0;
				pad_left_q   <= pads;
				tl_q         <= tl_end;
			end
			if (cmd.pad_emit) begin
				pad_left_q <= pad_left_q - PAD_W'(1);
			end
			if (byte_done || cmd.accept_end || cmd.pad_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_done) begin
			out_data_q <= buffer_next;
			out_last_q <= 1'b0;
			out_tl_q   <= 1'b0;
		end else if (cmd.accept_end) begin
			out_data_q <= fin;
			out_last_q <= pads == '0;
			out_tl_q   <= (pads == '0) && tl_end;
		end else if (cmd.pad_emit) begin
			out_data_q <= PAD_BYTE;
			out_last_q <= status.pad_last;
			out_tl_q   <= status.pad_last && tl_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign out_last     = out_last_q;
	assign out_too_long = out_tl_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_done || cmd.accept_end || cmd.pad_emit) && out_valid_q |-> out_ready)
		else $error("output register overwritten before transaction");

	a_pad_clean_state: assert property (@(posedge clk) disable iff (!arst_n)
		pad_left_q != '0 |-> bit_count_q == '0 && byte_count_q == '0 && level_q == '0)
		else $error("packing state not cleared during padding");

	a_tl_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tl_q |-> out_last_q)
		else $error("too_long flag set on a byte that is not last");

	a_pad_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pad_emit |=> pad_left_q == $past(pad_left_q) - PAD_W'(1))
		else $error("pad counter did not step");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/delta_modulation_byte_packer.sv
// top level of the delta modulation byte packer
// joins dmbp_ctrl and dmbp_datapath; uses dmbp_pkg
//
// One-bit delta modulator: each Q1.15 sample on the slave side yields one bit
// (1 when the tracking level, in 1/64 steps, lies below the sample), packed LSB
// first into bytes on the master side. Samples stream at one per cycle while the
// output register drains; a byte leaves every eighth sample. An end transaction
// (tuser high) emits the final byte, odd unused bit positions set, then 0xAA
// padding up to 16n+1 bytes in total, one byte per cycle from the pad counter
// while the output register drains: 1 to 16 output transactions, during which no
// input is taken. tlast marks the final byte, and tuser on it flags that n exceeds
// 255. The block then returns to its reset state.
`default_nettype none

module delta_modulation_byte_packer
	import dmbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	input  wire logic        s_tuser,   // [0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] data_byte
	output logic             m_tlast,
	output logic             m_tuser    // [0] too_long
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	dmbp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_ready   (s_tready),
		.status     (status),
		.cmd        (cmd)
	);

	dmbp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (s_tdata),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_data     (m_tdata),
		.out_last     (m_tlast),
		.out_too_long (m_tuser)
	);

endmodule

`default_nettype wire
